/* src/bts_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear texel sampler package
// Shared widths, default sizes and codes for the sampler and its testbench-free
// design files.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int DIM_W   = 9;
   localparam int INDEX_W = 16;
   localparam int TEXEL_W = 8;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 16;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic {
      CSR_TEX_WIDTH  = 1'b0,
      CSR_TEX_HEIGHT = 1'b1
   } csr_index_type;

endpackage

/* src/bts_ram.sv */
// ----------------------------------------------------------------------------
// Texel RAM
// Generic single-write, dual-read memory with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/bilinear_texel_sampler.sv */
// ----------------------------------------------------------------------------
// Bilinear texel sampler
// Single-channel 8-bit texture store with a six-stage bilinear sample pipeline.
// ----------------------------------------------------------------------------
// A req beat with tuser clear writes tdata's texel value at its row-major
// index and gives no rsp beat. A req beat with tuser set samples the texture
// at the normalized coordinates in tdata and gives one rsp beat holding the
// interpolated value in 8.FRAC_BITS fixed point on the raw texel scale.
// The csr port sets texture width and height; write it only while idle.
// rsp_tvalid is driven by the last stage's valid register. One beat is
// accepted per cycle unless the pipeline stalls; the rate is set by the four
// texel reads per sample, served by two store copies with two read ports each.
// Each stage advances when it is empty or the next stage advances, so bubbles
// close up while rsp_tready is low and req_tready falls only when all six
// stages are full. Reset empties the pipeline and sets both dimensions to
// 256 (clamped to the maxima); texel contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler #(
   parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = bts_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // texel_index, texel_value, coord_x, coord_y, zero padding
   input  logic [((bts_pkg::INDEX_W + bts_pkg::TEXEL_W + 2 * (FRAC_BITS + 1) + 7) / 8) * 8 - 1:0]
                req_tdata,
   // func
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // sample_value, zero padding
   output logic [((bts_pkg::TEXEL_W + FRAC_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                          csr_we,
   input  bts_pkg::csr_index_type        csr_addr,
   input  logic [bts_pkg::DIM_W-1:0]     csr_wdata
);

   import bts_pkg::*;

   localparam int CW     = FRAC_BITS + 1;
   localparam int SW     = CW + DIM_W;
   localparam int OUT_W  = TEXEL_W + FRAC_BITS;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int RSP_W  = ((OUT_W + 7) / 8) * 8;
   localparam int HW     = TEXEL_W + FRAC_BITS + 2;
   localparam int PW     = OUT_W + FRAC_BITS + 2;
   localparam int VAL_LSB = INDEX_W;
   localparam int CX_LSB = INDEX_W + TEXEL_W;
   localparam int CY_LSB = CX_LSB + CW;

   localparam logic [CW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0] HALF =
      {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(maxv)) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] hblend(input logic [TEXEL_W-1:0] a,
                                               input logic [TEXEL_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] f);
      logic signed [HW-1:0] d;
      logic signed [HW-1:0] p;
      logic signed [HW-1:0] s;
      d = $signed({2'b00, b}) - $signed({2'b00, a});
      p = d * $signed({1'b0, f});
      s = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + p;
      return s[OUT_W-1:0];
   endfunction

   // Texture dimensions, held clamped.
   logic [DIM_W-1:0] wdim_ff, wm1_ff, hm1_ff;
   logic [DIM_W-1:0] wdim_in, hdim_in;

   assign wdim_in = clamp_dim(csr_wdata, MAX_WIDTH);
   assign hdim_in = clamp_dim(csr_wdata, MAX_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         wdim_ff <= clamp_dim(DIM_RESET, MAX_WIDTH);
         wm1_ff  <= clamp_dim(DIM_RESET, MAX_WIDTH) - DIM_W'(1);
         hm1_ff  <= clamp_dim(DIM_RESET, MAX_HEIGHT) - DIM_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TEX_WIDTH: begin
               wdim_ff <= wdim_in;
               wm1_ff  <= wdim_in - DIM_W'(1);
            end
            CSR_TEX_HEIGHT: begin
               hm1_ff <= hdim_in - DIM_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Stage valids and advance enables.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s1_load, s2_load, s3_load, s4_load, s5_load, s6_load;

   assign s6_load = !s6_valid_ff || rsp_tready;
   assign s5_load = !s5_valid_ff || s6_load;
   assign s4_load = !s4_valid_ff || s5_load;
   assign s3_load = !s3_valid_ff || s4_load;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;

   assign req_tready = s1_load;
   assign rsp_tvalid = s6_valid_ff;

   // Stage payloads.
   logic                 s1_sample_ff, s2_sample_ff, s3_sample_ff;
   logic [INDEX_W-1:0]   s1_index_ff, s2_index_ff, s3_index_ff;
   logic [TEXEL_W-1:0]   s1_value_ff, s2_value_ff, s3_value_ff;
   logic [CW-1:0]        s1_cx_ff, s1_cy_ff;
   logic [DIM_W-1:0]     s2_x0_ff, s2_y0_ff, s3_x0_ff, s3_x1_ff;
   logic [FRAC_BITS-1:0] s2_fx_ff, s2_fy_ff, s3_fx_ff, s3_fy_ff;
   logic [FRAC_BITS-1:0] s4_fx_ff, s4_fy_ff, s5_fy_ff;
   logic [AW-1:0]        s3_row0_ff, s3_row1_ff;
   logic [OUT_W-1:0]     s5_top_ff, s5_bot_ff, s6_out_ff;

   logic [CW-1:0]        cx_in, cy_in;
   logic [SW-1:0]        sx_in, sy_in;
   logic [DIM_W-1:0]     x1_in, y1_in;
   logic [2*DIM_W-1:0]   row0_in, row1_in;
   logic [AW-1:0]        addr00, addr01, addr10, addr11;
   logic                 wr_en;
   logic [TEXEL_W-1:0]   t00, t01, t10, t11;
   logic signed [PW-1:0] vd, vp, vr, vs;
   logic [OUT_W-1:0]     out_in;

   always_comb begin
      cx_in = req_tdata[CX_LSB +: CW];
      cy_in = req_tdata[CY_LSB +: CW];
      if (cx_in > ONE_FIX) begin
         cx_in = ONE_FIX;
      end
      if (cy_in > ONE_FIX) begin
         cy_in = ONE_FIX;
      end
   end

   assign sx_in = SW'(s1_cx_ff) * SW'(wm1_ff);
   assign sy_in = SW'(s1_cy_ff) * SW'(hm1_ff);

   assign x1_in   = (s2_x0_ff == wm1_ff) ? s2_x0_ff : s2_x0_ff + DIM_W'(1);
   assign y1_in   = (s2_y0_ff == hm1_ff) ? s2_y0_ff : s2_y0_ff + DIM_W'(1);
   assign row0_in = (2*DIM_W)'(s2_y0_ff) * (2*DIM_W)'(wdim_ff);
   assign row1_in = (2*DIM_W)'(y1_in) * (2*DIM_W)'(wdim_ff);

   assign addr00 = s3_row0_ff + AW'(s3_x0_ff);
   assign addr01 = s3_row0_ff + AW'(s3_x1_ff);
   assign addr10 = s3_row1_ff + AW'(s3_x0_ff);
   assign addr11 = s3_row1_ff + AW'(s3_x1_ff);

   assign wr_en = s3_valid_ff && (s3_sample_ff == FUNC_WRITE) && s4_load &&
                  (32'(s3_index_ff) < 32'(DEPTH));

   always_comb begin
      vd     = $signed({1'b0, s5_bot_ff}) - $signed({1'b0, s5_top_ff});
      vp     = vd * $signed({1'b0, s5_fy_ff});
      vr     = vp + HALF;
      vs     = vr >>> FRAC_BITS;
      out_in = s5_top_ff + vs[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_load) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_load) begin
            s4_valid_ff <= s3_valid_ff && (s3_sample_ff == FUNC_SAMPLE);
         end
         if (s5_load) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s6_load) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sample_ff <= (req_tuser == FUNC_SAMPLE);
         s1_index_ff  <= req_tdata[INDEX_W-1:0];
         s1_value_ff  <= req_tdata[VAL_LSB +: TEXEL_W];
         s1_cx_ff     <= cx_in;
         s1_cy_ff     <= cy_in;
      end
      if (s2_load) begin
         s2_sample_ff <= s1_sample_ff;
         s2_index_ff  <= s1_index_ff;
         s2_value_ff  <= s1_value_ff;
         s2_x0_ff     <= sx_in[FRAC_BITS +: DIM_W];
         s2_y0_ff     <= sy_in[FRAC_BITS +: DIM_W];
         s2_fx_ff     <= sx_in[FRAC_BITS-1:0];
         s2_fy_ff     <= sy_in[FRAC_BITS-1:0];
      end
      if (s3_load) begin
         s3_sample_ff <= s2_sample_ff;
         s3_index_ff  <= s2_index_ff;
         s3_value_ff  <= s2_value_ff;
         s3_x0_ff     <= s2_x0_ff;
         s3_x1_ff     <= x1_in;
         s3_row0_ff   <= AW'(row0_in);
         s3_row1_ff   <= AW'(row1_in);
         s3_fx_ff     <= s2_fx_ff;
         s3_fy_ff     <= s2_fy_ff;
      end
      if (s4_load) begin
         s4_fx_ff <= s3_fx_ff;
         s4_fy_ff <= s3_fy_ff;
      end
      if (s5_load) begin
         s5_top_ff <= hblend(t00, t01, s4_fx_ff);
         s5_bot_ff <= hblend(t10, t11, s4_fx_ff);
         s5_fy_ff  <= s4_fy_ff;
      end
      if (s6_load) begin
         s6_out_ff <= out_in;
      end
   end

   // Two identical copies of the store: one serves the upper row, one the lower.
   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (DEPTH)
   ) u_ram_upper (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(s3_index_ff)),
      .wr_data   (s3_value_ff),
      .rd_en     (s4_load),
      .rd_addr_a (addr00),
      .rd_addr_b (addr01),
      .rd_data_a (t00),
      .rd_data_b (t01)
   );

   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (DEPTH)
   ) u_ram_lower (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(s3_index_ff)),
      .wr_data   (s3_value_ff),
      .rd_en     (s4_load),
      .rd_addr_a (addr10),
      .rd_addr_b (addr11),
      .rd_data_a (t10),
      .rd_data_b (t11)
   );

   assign rsp_tdata = RSP_W'(s6_out_ff);

endmodule
